>>> src/fixed_point_newton_divide_unit_defines.svh
// Assertion macros for the Newton-Raphson Q8.8 divider.
// Depends on nothing; taken in by the top level with `include.
`ifndef FIXED_POINT_NEWTON_DIVIDE_UNIT_DEFINES_SVH
`define FIXED_POINT_NEWTON_DIVIDE_UNIT_DEFINES_SVH

// Checked only outside reset.
`define FPND_ASSERT_RUN(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FPND_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/fpnd_pkg.sv
// Constants and the Q8.8 fixed multiply shared by the divider.
// Depends on nothing.
package fpnd_pkg;

	localparam int unsigned MAG_W  = 15;
	localparam int unsigned NORM_W = 9;
	localparam int unsigned SH_W   = 3;

	localparam logic [15:0] SEED_BASE  = 16'h02EA;
	localparam logic [15:0] NEWTON_TWO = 16'h0200;
	localparam logic [15:0] NORM_HIGH  = 16'h0100;
	localparam logic [15:0] NORM_LOW   = 16'h0080;
	localparam logic [15:0] SIGN_BIT16 = 16'h8000;

	// Full signed product, floor shift by 8, wrap to 16 bits.
	function automatic logic signed [15:0] qmul(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [31:0] prod;
		prod = a * b;
		return prod[23:8];
	endfunction

endpackage

>>> src/fixed_point_newton_divide_unit.sv
// Signed Q8.8 divider: Newton-Raphson reciprocal, eight-stage pipeline.
// Throughput: one transaction per cycle unless out_ready stalls the output; no stage holds more than one multiplier.
// Stalls hold stages that are full; empty stages keep filling (bubbles collapse).
// arst_n (async, active low) clears all valid bits; data registers are not reset.
// Uses fpnd_pkg and fixed_point_newton_divide_unit_defines.svh.
`include "fixed_point_newton_divide_unit_defines.svh"

module fixed_point_newton_divide_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] numerator,
	input  logic signed [15:0] divisor,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] quotient,
	output logic               divide_error
);

	// Side data that rides along stages 1 to 7; stage 2 fills in the shift fields.
	typedef struct packed {
		logic signed [15:0]               nn;
		logic                             neg;
		logic                             err;
		logic [fpnd_pkg::SH_W-1:0]        shl;
		logic [fpnd_pkg::SH_W-1:0]        shr;
	} side_t;

	// Valid bits per stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	// Stage enables: a stage loads when it is empty or its successor moves.
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	assign en8 = !v_s8 || out_ready;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	// ---------------- Stage 1: magnitude and error detect ----------------
	side_t                         sd_s1;
	logic [fpnd_pkg::MAG_W-1:0]    dmag_s1;
	logic [15:0]                   dneg;

	assign dneg = 16'(-divisor);

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			sd_s1.nn  <= numerator;
			sd_s1.neg <= divisor[15];
			// zero and the most negative value have no usable reciprocal
			sd_s1.err <= (divisor == 16'sd0) || (divisor == fpnd_pkg::SIGN_BIT16);
			sd_s1.shl <= '0;
			sd_s1.shr <= '0;
			dmag_s1   <= divisor[15] ? dneg[14:0] : divisor[14:0];
		end
	end

	// ---------------- Stage 2: normalize into [0x80, 0x100] ----------------
	side_t                         sd_s2;
	logic [fpnd_pkg::NORM_W-1:0]   dn_s2;
	logic [fpnd_pkg::SH_W-1:0]     nrm_shr, nrm_shl, lead;
	logic [fpnd_pkg::MAG_W-1:0]    nrm_d;

	always_comb begin
		nrm_shr = '0;
		nrm_shl = '0;
		lead    = '0;
		nrm_d   = dmag_s1;
		if ({1'b0, dmag_s1} > fpnd_pkg::NORM_HIGH) begin
			// smallest right shift that brings the value to 0x100 or below
			for (int k = 7; k >= 1; k--) begin
				if ({1'b0, (dmag_s1 >> k)} <= fpnd_pkg::NORM_HIGH)
					nrm_shr = fpnd_pkg::SH_W'(k);
			end
			nrm_d = dmag_s1 >> nrm_shr;
		end else if ({1'b0, dmag_s1} < fpnd_pkg::NORM_LOW) begin
			for (int p = 0; p < 7; p++) begin
				if (dmag_s1[p])
					lead = fpnd_pkg::SH_W'(p);
			end
			nrm_shl = 3'd7 - lead;
			nrm_d   = dmag_s1 << nrm_shl;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			sd_s2 <= '{nn: sd_s1.nn, neg: sd_s1.neg, err: sd_s1.err,
				shl: nrm_shl, shr: nrm_shr};
			dn_s2 <= nrm_d[fpnd_pkg::NORM_W-1:0];
		end
	end

	// ---------------- Stage 3: seed and first d*x ----------------
	side_t                         sd_s3;
	logic [fpnd_pkg::NORM_W-1:0]   dn_s3;
	logic signed [15:0]            x0_s3, m1_s3;
	logic signed [15:0]            seed;

	assign seed = fpnd_pkg::SEED_BASE - {6'd0, dn_s2, 1'b0};

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			sd_s3 <= sd_s2;
			dn_s3 <= dn_s2;
			x0_s3 <= seed;
			m1_s3 <= fpnd_pkg::qmul({7'd0, dn_s2}, seed);
		end
	end

	// ---------------- Stage 4: first refinement x1 = x0*(2 - d*x0) ----------------
	side_t                         sd_s4;
	logic [fpnd_pkg::NORM_W-1:0]   dn_s4;
	logic signed [15:0]            x1_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			sd_s4 <= sd_s3;
			dn_s4 <= dn_s3;
			x1_s4 <= fpnd_pkg::qmul(x0_s3, fpnd_pkg::NEWTON_TWO - m1_s3);
		end
	end

	// ---------------- Stage 5: second d*x ----------------
	side_t                         sd_s5;
	logic signed [15:0]            x1_s5, m2_s5;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			sd_s5 <= sd_s4;
			x1_s5 <= x1_s4;
			m2_s5 <= fpnd_pkg::qmul({7'd0, dn_s4}, x1_s4);
		end
	end

	// ---------------- Stage 6: second refinement ----------------
	side_t                         sd_s6;
	logic signed [15:0]            x2_s6;

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			sd_s6 <= sd_s5;
			x2_s6 <= fpnd_pkg::qmul(x1_s5, fpnd_pkg::NEWTON_TWO - m2_s5);
		end
	end

	// ---------------- Stage 7: undo normalization, restore sign ----------------
	side_t                         sd_s7;
	logic signed [15:0]            xr_s7;
	logic signed [15:0]            xsh;

	always_comb begin
		if (sd_s6.shl != '0)
			xsh = x2_s6 << sd_s6.shl;    // wraps at 16 bits
		else
			xsh = x2_s6 >>> sd_s6.shr;   // floor shift; zero shift passes through
	end

	always_ff @(posedge clk) begin
		if (en7 && v_s6) begin
			sd_s7 <= sd_s6;
			xr_s7 <= sd_s6.neg ? 16'(-xsh) : xsh;
		end
	end

	// ---------------- Stage 8: multiply by numerator, output register ----------------
	logic signed [15:0]            q_s8;
	logic                          err_s8;

	always_ff @(posedge clk) begin
		if (en8 && v_s7) begin
			err_s8 <= sd_s7.err;
			q_s8   <= sd_s7.err ? 16'sd0 : fpnd_pkg::qmul(xr_s7, sd_s7.nn);
		end
	end

	assign out_valid    = v_s8;
	assign quotient     = q_s8;
	assign divide_error = err_s8;

	// ---------------- Assertions ----------------
	`FPND_ASSERT_RUN(a_err_zero, out_valid && divide_error |-> quotient == 16'sd0, "error result with nonzero quotient")
	`FPND_ASSERT_RUN(a_empty_ready, !out_valid |-> in_ready, "input blocked while output register empty")
	`FPND_ASSERT_ALWAYS(a_reset_clear, !arst_n |-> !out_valid, "output valid during reset")

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the signed Q8.8 Newton-Raphson divider.
// It predicts every quotient and error flag in its own code and compares them with the DUT.
// Depends on fpnd_pkg and the fixed_point_newton_divide_unit RTL.

module testbench;

	// No transaction for this many cycles means the DUT is hung.
	localparam int WATCHDOG_LIMIT = 5000;
	// Settle time after the last result; the pipeline is 8 stages deep.
	localparam int DRAIN_CYCLES   = 24;
	localparam int HOLD_OFF_LEN   = 250;

	typedef struct packed {
		logic signed [15:0] quotient;
		logic               divide_error;
	} division_result_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b1;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic signed [15:0] numerator    = '0;
	logic signed [15:0] divisor      = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic signed [15:0] quotient;
	logic               divide_error;

	// Predicted results in transaction order; the pipeline never reorders.
	division_result_t pending_quotients[$];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int hold_off_request   = 0;	// written by a test, taken by the receiver
	int hold_off_left      = 0;
	int divisions_sent     = 0;
	int results_checked    = 0;
	int error_results      = 0;
	int input_stalls       = 0;
	int mismatches         = 0;
	int quiet_cycles       = 0;

	fixed_point_newton_divide_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.numerator   (numerator),
		.divisor     (divisor),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.quotient    (quotient),
		.divide_error(divide_error)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Quotient predictor
	// ---------------------------------------------------------------

	// Keep the low 16 bits and sign-extend them back to an int.
	function automatic int wrap_q(input int v);
		logic signed [15:0] t;
		t = v[15:0];
		return int'(t);
	endfunction

	// Q8.8 multiply: full product, floor shift by 8, wrap to 16 bits.
	function automatic int fixed_mul(input int a, input int b);
		int prod;
		prod = a * b;
		return wrap_q(prod >>> 8);
	endfunction

	function automatic division_result_t compute_quotient(input logic signed [15:0] num,
			input logic signed [15:0] den);
		division_result_t res;
		int               mag;
		int               recip;
		int               shift;
		logic             flip;
		res.quotient     = '0;
		res.divide_error = 1'b1;
		// Zero and the most negative divisor have no usable magnitude.
		if (den == 16'sh0000 || den == fpnd_pkg::SIGN_BIT16)
			return res;
		flip  = (den < 0);
		mag   = flip ? -int'(den) : int'(den);
		shift = 0;
		// Normalize the magnitude into [0x80, 0x100], counting the shifts.
		while (mag > int'(fpnd_pkg::NORM_HIGH)) begin
			shift--;
			mag >>= 1;
		end
		while (mag < int'(fpnd_pkg::NORM_LOW)) begin
			shift++;
			mag <<= 1;
		end
		// Linear seed, then two Newton steps x = x * (2 - d * x).
		recip = int'(fpnd_pkg::SEED_BASE) - (mag << 1);
		repeat (2)
			recip = fixed_mul(recip,
				wrap_q(int'(fpnd_pkg::NEWTON_TWO) - fixed_mul(mag, recip)));
		// Undo normalization: left shifts wrap, right shifts are arithmetic.
		if (shift > 0)
			recip = wrap_q(recip << shift);
		else if (shift < 0)
			recip = recip >>> (-shift);
		if (flip)
			recip = wrap_q(-recip);
		res.quotient     = 16'(fixed_mul(recip, int'(num)));
		res.divide_error = 1'b0;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Reporting, monitor, receiver, watchdog
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH @%0t: %s: got %0d (0x%04h), expected %0d (0x%04h)",
			$time, what, got, got[15:0], want, want[15:0]);
		mismatches++;
	endtask

	// Samples both channels at the edge; the DUT and the driver only update
	// through nonblocking assignments, so every value read here is pre-edge.
	always @(posedge clk) begin : transaction_monitor
		division_result_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (out_valid && out_ready) begin
				quiet_cycles = 0;
				results_checked++;
				if (divide_error)
					error_results++;
				if (pending_quotients.size() == 0) begin
					report_mismatch("result with no transaction pending", quotient, 0);
				end else begin
					want = pending_quotients.pop_front();
					if (quotient !== want.quotient)
						report_mismatch("quotient", quotient, want.quotient);
					if (divide_error !== want.divide_error)
						report_mismatch("divide_error", divide_error, want.divide_error);
				end
			end
			// Output check goes first: a result never leaves in the cycle its
			// transaction enters, so queue order is preserved.
			if (in_valid && in_ready) begin
				quiet_cycles = 0;
				divisions_sent++;
				pending_quotients.push_back(compute_quotient(numerator, divisor));
			end else if (in_valid) begin
				input_stalls++;
			end
		end
	end

	// Result sink: random stalls, plus a long hold-off when a test asks.
	always @(posedge clk) begin
		if (hold_off_request != 0) begin
			hold_off_left    = hold_off_request;
			hold_off_request = 0;
		end
		if (hold_off_left != 0) begin
			hold_off_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	initial begin : watchdog
		wait (arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, pending_quotients.size());
		$display("** fixed_point_newton_divide_unit: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Offers one division and returns at the edge where it is accepted.
	// Valid stays high on return so back-to-back transactions need no gap.
	task automatic send_division(input logic signed [15:0] num,
			input logic signed [15:0] den);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid  <= 1'b1;
		numerator <= num;
		divisor   <= den;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Drops valid after the last accepted transaction of a test.
	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] random_divisor();
		logic signed [15:0] mag;
		case ($urandom_range(9))
			0: begin
				return $urandom_range(1) ? 16'sh0000 : fpnd_pkg::SIGN_BIT16;
			end
			1, 2: begin
				// Small magnitudes exercise the left-shift normalization.
				mag = 16'($urandom_range(1, 16'h0200));
			end
			3: begin
				mag = 16'sh0001 << $urandom_range(14);
			end
			default: begin
				return 16'($urandom());
			end
		endcase
		return $urandom_range(1) ? -mag : mag;
	endfunction

	function automatic logic signed [15:0] random_numerator();
		logic signed [15:0] mag;
		if ($urandom_range(3) == 0) begin
			mag = 16'($urandom_range(16'h03FF));
			return $urandom_range(1) ? -mag : mag;
		end
		return 16'($urandom());
	endfunction

	task automatic send_random_divisions(input int count);
		repeat (count)
			send_division(random_numerator(), random_divisor());
		stop_sending();
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	task automatic reset_dut();
		arst_n <= 1'b0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
	endtask

	task automatic test_directed_cases();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		// Error cases: zero and most negative divisor, with live numerators.
		send_division(16'sh0100, 16'sh0000);
		send_division(16'sh7FFF, 16'sh0000);
		send_division(-16'sh0100, fpnd_pkg::SIGN_BIT16);
		send_division(fpnd_pkg::SIGN_BIT16, fpnd_pkg::SIGN_BIT16);
		// Exact unit and the edges of the normalization window.
		send_division(16'sh0100, 16'sh0100);
		send_division(16'sh0300, 16'sh0080);
		send_division(16'sh0300, 16'sh00FF);
		send_division(16'sh0300, 16'sh0101);
		send_division(16'sh0300, 16'sh0200);
		// Largest left and right normalization shifts.
		send_division(16'sh0001, 16'sh0001);
		send_division(16'sh7FFF, 16'sh0001);
		send_division(16'sh7FFF, 16'sh7FFF);
		send_division(fpnd_pkg::SIGN_BIT16, 16'sh7FFF);
		send_division(16'sh0100, -16'sh7FFF);
		send_division(16'sh0100, -16'sh0001);
		// Negative divisors and numerators, and a quotient that wraps.
		send_division(-16'sh0001, -16'sh0100);
		send_division(fpnd_pkg::SIGN_BIT16, -16'sh0100);
		send_division(fpnd_pkg::SIGN_BIT16, 16'sh0040);
		send_division(16'sh7FFF, 16'sh0040);
		send_division(16'sh0000, 16'sh0123);
		send_division(16'sh0000, -16'sh4000);
		send_division(-16'sh0500, 16'sh0003);
		stop_sending();
	endtask

	task automatic test_streaming_no_idle();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		send_random_divisions(500);
	endtask

	task automatic test_sender_gaps();
		sender_idle_pct    = 81;
		receiver_stall_pct = 0;
		send_random_divisions(450);
	endtask

	task automatic test_receiver_stalls();
		sender_idle_pct    = 0;
		receiver_stall_pct = 81;
		send_random_divisions(450);
	endtask

	task automatic test_mixed_idling();
		sender_idle_pct    = 35;
		receiver_stall_pct = 35;
		send_random_divisions(500);
	endtask

	// Sink holds off long enough for the pipeline to fill and push back
	// on the input, while the source keeps offering transactions.
	task automatic test_output_hold_off();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_off_request   = HOLD_OFF_LEN;
		send_random_divisions(80);
	endtask

	task automatic drain_results();
		while (pending_quotients.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		reset_dut();
		test_directed_cases();
		test_streaming_no_idle();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();
		test_output_hold_off();
		drain_results();
		$display("Coverage: %0d divisions sent, %0d results checked, %0d flagged as errors,",
			divisions_sent, results_checked, error_results);
		$display("  %0d input stall cycles over idle, stall and hold-off phases; %0d mismatches",
			input_stalls, mismatches);
		if (mismatches == 0 && pending_quotients.size() == 0) begin
			$display("** fixed_point_newton_divide_unit: PASSED **");
		end else begin
			$display("** fixed_point_newton_divide_unit: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/fpnd_pkg.sv
src/fixed_point_newton_divide_unit.sv
dv/testbench.sv
